### rtl/gufwc_pkg.sv
package gufwc_pkg;

    // Grid capacity; cell (x, y) lives at entry y * MAX_COLUMNS + x.
    localparam int MAX_COLUMNS = 32;
    localparam int MAX_ROWS    = 32;
    localparam int CELL_COUNT  = MAX_COLUMNS * MAX_ROWS;
    localparam int CELL_W      = $clog2(CELL_COUNT);

    // Field widths.
    localparam int CFG_W    = 6;
    localparam int X_W      = 5;
    localparam int Y_W      = 5;
    localparam int DIR_W    = 2;
    localparam int STATUS_W = 2;
    localparam int MASK_W   = 4;

    // Width for grid bound compares (config value vs capacity vs coordinate + 1).
    localparam int MAX_DIM = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
    localparam int CMP_W   = $clog2(MAX_DIM + (1 << CFG_W)) + 1;

    // Register port.
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int GRID_RESET  = 32;

    localparam logic [MASK_W-1:0] WALLS_ALL = '1;

    typedef enum logic [DIR_W-1:0] {
        DIR_Y_UP   = 2'd0,
        DIR_X_UP   = 2'd1,
        DIR_Y_DOWN = 2'd2,
        DIR_X_DOWN = 2'd3
    } t_dir;

    typedef enum logic [STATUS_W-1:0] {
        STS_REMOVED   = 2'd0,
        STS_CONNECTED = 2'd1,
        STS_OUTSIDE   = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } t_reg_idx;

    // Microprogram steps.
    typedef enum logic [3:0] {
        ST_CLEAR  = 4'd0,
        ST_IDLE   = 4'd1,
        ST_CHECK  = 4'd2,
        ST_HERE   = 4'd3,
        ST_WALK1  = 4'd4,
        ST_SEEK2  = 4'd5,
        ST_THERE  = 4'd6,
        ST_WALK2  = 4'd7,
        ST_LINK   = 4'd8,
        ST_WALLS2 = 4'd9,
        ST_EMIT   = 4'd10
    } t_step;

    // Datapath operations.
    typedef enum logic [3:0] {
        ACT_CLEAR,
        ACT_WAIT,
        ACT_FETCH,
        ACT_HERE_MASK,
        ACT_WALK,
        ACT_SEEK2,
        ACT_NBR_MASK,
        ACT_LINK,
        ACT_WALL2,
        ACT_EMIT
    } t_act;

    // Jump conditions.
    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_CLR_DONE,
        C_ACCEPT,
        C_CELL_OUT,
        C_NBR_OUT,
        C_ROOT,
        C_SAME
    } t_cond;

    // C_OUT_FREE is kept as a separate bit so that t_cond stays within 3 bits.
    typedef struct packed {
        t_act       act;
        t_cond      cond;
        logic       cond_out_free;  // EMIT waits on the output register
        t_step      target;
        logic       stay;           // hold step when condition is false
    } t_uword;

    typedef struct packed {
        logic clr_done;
        logic accept;
        logic cell_out;
        logic nbr_out;
        logic root;
        logic same;
        logic out_free;
    } t_flags;

    function automatic t_uword uprog(input t_step s);
        t_uword w;
        w = '{act: ACT_WAIT, cond: C_ALWAYS, cond_out_free: 1'b0,
              target: ST_IDLE, stay: 1'b0};
        unique case (s)
            ST_CLEAR:  w = '{act: ACT_CLEAR, cond: C_CLR_DONE, cond_out_free: 1'b0,
                             target: ST_IDLE, stay: 1'b1};
            ST_IDLE:   w = '{act: ACT_WAIT, cond: C_ACCEPT, cond_out_free: 1'b0,
                             target: ST_CHECK, stay: 1'b1};
            ST_CHECK:  w = '{act: ACT_FETCH, cond: C_CELL_OUT, cond_out_free: 1'b0,
                             target: ST_EMIT, stay: 1'b0};
            ST_HERE:   w = '{act: ACT_HERE_MASK, cond: C_NBR_OUT, cond_out_free: 1'b0,
                             target: ST_EMIT, stay: 1'b0};
            ST_WALK1:  w = '{act: ACT_WALK, cond: C_ROOT, cond_out_free: 1'b0,
                             target: ST_SEEK2, stay: 1'b1};
            ST_SEEK2:  w = '{act: ACT_SEEK2, cond: C_NONE, cond_out_free: 1'b0,
                             target: ST_IDLE, stay: 1'b0};
            ST_THERE:  w = '{act: ACT_NBR_MASK, cond: C_NONE, cond_out_free: 1'b0,
                             target: ST_IDLE, stay: 1'b0};
            ST_WALK2:  w = '{act: ACT_WALK, cond: C_ROOT, cond_out_free: 1'b0,
                             target: ST_LINK, stay: 1'b1};
            ST_LINK:   w = '{act: ACT_LINK, cond: C_SAME, cond_out_free: 1'b0,
                             target: ST_EMIT, stay: 1'b0};
            ST_WALLS2: w = '{act: ACT_WALL2, cond: C_NONE, cond_out_free: 1'b0,
                             target: ST_IDLE, stay: 1'b0};
            ST_EMIT:   w = '{act: ACT_EMIT, cond: C_NONE, cond_out_free: 1'b1,
                             target: ST_IDLE, stay: 1'b1};
            default:   w = '{act: ACT_WAIT, cond: C_ALWAYS, cond_out_free: 1'b0,
                             target: ST_IDLE, stay: 1'b0};
        endcase
        return w;
    endfunction

endpackage

### rtl/gufwc_req_if.sv
interface gufwc_req_if;
    logic                         valid;
    logic                         ready;
    logic [gufwc_pkg::X_W-1:0]    cell_x;
    logic [gufwc_pkg::Y_W-1:0]    cell_y;
    logic [gufwc_pkg::DIR_W-1:0]  direction;

    modport source (output valid, output cell_x, output cell_y, output direction,
                    input ready);
    modport sink   (input valid, input cell_x, input cell_y, input direction,
                    output ready);
endinterface

### rtl/gufwc_rsp_if.sv
interface gufwc_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [gufwc_pkg::STATUS_W-1:0] status;
    logic [gufwc_pkg::MASK_W-1:0]   walls_here;
    logic [gufwc_pkg::MASK_W-1:0]   walls_neighbor;

    modport source (output valid, output status, output walls_here,
                    output walls_neighbor, input ready);
    modport sink   (input valid, input status, input walls_here,
                    input walls_neighbor, output ready);
endinterface

### rtl/grid_union_find_wall_carver.sv
// Grid union-find wall carver.
// i_req carries one wall request per item (cell_x, cell_y, direction); o_rsp
// returns one item per request (status, walls_here, walls_neighbor). Both use
// valid/ready; an item moves on a clock edge with valid and ready high.
// The APB port sets grid_width (0x0) and grid_height (0x4); write only while
// no request is in flight. pready is tied high, prdata reads back the register.
// Requests are served one at a time. A request whose cell or neighbour lies
// outside the grid ends after the cell check or after the cell's wall mask is
// read; otherwise the sequencer walks the cell and then the neighbour to their
// roots and links the two roots (not when already connected) before the result
// is registered. The parent table has one read port, so each walk reads one
// parent link at a time. The next request can be taken in the cycle after the
// result is loaded into the output register.
// Reset: the microprogram first sweeps all CELL_COUNT entries of both tables
// (parent = self, all walls standing), one entry per cycle; i_req.ready stays
// low meanwhile, register writes are accepted as usual.
// Stall: a result waits in the output register; if the previous one is still
// held, the sequencer parks in its emit step until o_rsp.ready frees it.
module grid_union_find_wall_carver (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    gufwc_req_if.sink                           i_req,
    gufwc_rsp_if.source                         o_rsp,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gufwc_pkg::PADDR_W-1:0]       paddr,
    input  logic [gufwc_pkg::PDATA_W-1:0]       pwdata,
    output logic [gufwc_pkg::PDATA_W-1:0]       prdata,
    output logic                                pready
);

    localparam int CELL_W = gufwc_pkg::CELL_W;
    localparam int CMP_W  = gufwc_pkg::CMP_W;
    localparam int MASK_W = gufwc_pkg::MASK_W;
    localparam int CFG_W  = gufwc_pkg::CFG_W;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [CFG_W-1:0] r_grid_width;
    logic [CFG_W-1:0] r_grid_height;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= CFG_W'(gufwc_pkg::GRID_RESET);
            r_grid_height <= CFG_W'(gufwc_pkg::GRID_RESET);
        end else if (cfg_wr) begin
            unique case (gufwc_pkg::t_reg_idx'(paddr[2]))
                gufwc_pkg::REG_GRID_WIDTH:  r_grid_width  <= pwdata[CFG_W-1:0];
                gufwc_pkg::REG_GRID_HEIGHT: r_grid_height <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (gufwc_pkg::t_reg_idx'(paddr[2]))
            gufwc_pkg::REG_GRID_WIDTH:  prdata = gufwc_pkg::PDATA_W'(r_grid_width);
            gufwc_pkg::REG_GRID_HEIGHT: prdata = gufwc_pkg::PDATA_W'(r_grid_height);
            default:                    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    gufwc_pkg::t_uword uw;
    gufwc_pkg::t_flags fl;

    gufwc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (fl),
        .o_uword (uw)
    );

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    logic [CELL_W-1:0]      r_cur;       // walk cursor; sweep index after reset
    logic [CELL_W-1:0]      r_here;
    logic [CELL_W-1:0]      r_there;
    logic [CELL_W-1:0]      r_r1;        // root of the requested cell
    gufwc_pkg::t_dir        r_dir;
    logic                   r_cell_out;
    logic                   r_nbr_out;
    gufwc_pkg::t_status     r_status;
    logic [MASK_W-1:0]      r_wh;
    logic [MASK_W-1:0]      r_wn;

    logic                   r_out_valid;
    gufwc_pkg::t_status     r_out_status;
    logic [MASK_W-1:0]      r_out_wh;
    logic [MASK_W-1:0]      r_out_wn;

    // Tables, registered read data
    logic [CELL_W-1:0]      r_parent_mem [gufwc_pkg::CELL_COUNT];
    logic [MASK_W-1:0]      r_wall_mem   [gufwc_pkg::CELL_COUNT];
    logic [CELL_W-1:0]      r_pdata;
    logic [MASK_W-1:0]      r_wdata;

    // ---------------------------------------------------------------
    // Request decode (evaluated on the accept cycle)
    // ---------------------------------------------------------------
    logic              accept;
    logic              out_load;
    logic [CMP_W-1:0]  w_eff;
    logic [CMP_W-1:0]  h_eff;
    logic [CMP_W-1:0]  x_c;
    logic [CMP_W-1:0]  y_c;
    logic              in_cell_out;
    logic              in_nbr_out;
    logic [CELL_W-1:0] in_here;
    logic [CELL_W-1:0] in_there;

    assign i_req.ready = (uw.act == gufwc_pkg::ACT_WAIT);
    assign accept      = i_req.valid & i_req.ready;

    always_comb begin
        // oversized settings clamp to the table capacity
        w_eff = (CMP_W'(r_grid_width) > CMP_W'(gufwc_pkg::MAX_COLUMNS))
              ? CMP_W'(gufwc_pkg::MAX_COLUMNS) : CMP_W'(r_grid_width);
        h_eff = (CMP_W'(r_grid_height) > CMP_W'(gufwc_pkg::MAX_ROWS))
              ? CMP_W'(gufwc_pkg::MAX_ROWS) : CMP_W'(r_grid_height);
        x_c   = CMP_W'(i_req.cell_x);
        y_c   = CMP_W'(i_req.cell_y);

        in_cell_out = (x_c >= w_eff) || (y_c >= h_eff);
        in_here     = CELL_W'(int'(i_req.cell_y) * gufwc_pkg::MAX_COLUMNS
                              + int'(i_req.cell_x));

        unique case (gufwc_pkg::t_dir'(i_req.direction))
            gufwc_pkg::DIR_Y_UP: begin
                in_nbr_out = (y_c + CMP_W'(1)) >= h_eff;
                in_there   = CELL_W'(int'(in_here) + gufwc_pkg::MAX_COLUMNS);
            end
            gufwc_pkg::DIR_X_UP: begin
                in_nbr_out = (x_c + CMP_W'(1)) >= w_eff;
                in_there   = in_here + CELL_W'(1);
            end
            gufwc_pkg::DIR_Y_DOWN: begin
                in_nbr_out = (i_req.cell_y == '0);
                in_there   = CELL_W'(int'(in_here) - gufwc_pkg::MAX_COLUMNS);
            end
            default: begin
                in_nbr_out = (i_req.cell_x == '0);
                in_there   = in_here - CELL_W'(1);
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Condition flags
    // ---------------------------------------------------------------
    logic [MASK_W-1:0]  wh_cleared;
    logic [MASK_W-1:0]  wn_cleared;
    logic [1:0]         opp;

    assign opp        = r_dir + 2'd2;
    assign wh_cleared = r_wh & ~(MASK_W'(1) << r_dir);
    assign wn_cleared = r_wn & ~(MASK_W'(1) << opp);

    assign fl.clr_done = (r_cur == CELL_W'(gufwc_pkg::CELL_COUNT - 1));
    assign fl.accept   = accept;
    assign fl.cell_out = r_cell_out;
    assign fl.nbr_out  = r_nbr_out;
    assign fl.root     = (r_pdata == r_cur);
    assign fl.same     = (r_r1 == r_cur);
    assign fl.out_free = !r_out_valid || o_rsp.ready;

    assign out_load = (uw.act == gufwc_pkg::ACT_EMIT) && fl.out_free;

    // ---------------------------------------------------------------
    // Table ports
    // ---------------------------------------------------------------
    logic              parent_we;
    logic [CELL_W-1:0] parent_waddr;
    logic [CELL_W-1:0] parent_wdat;
    logic [CELL_W-1:0] parent_raddr;
    logic              wall_we;
    logic [CELL_W-1:0] wall_waddr;
    logic [MASK_W-1:0] wall_wdat;
    logic [CELL_W-1:0] wall_raddr;

    always_comb begin
        parent_we    = 1'b0;
        parent_waddr = r_r1;
        parent_wdat  = r_cur;
        parent_raddr = r_cur;
        wall_we      = 1'b0;
        wall_waddr   = r_here;
        wall_wdat    = wh_cleared;
        wall_raddr   = r_cur;
        unique case (uw.act)
            gufwc_pkg::ACT_CLEAR: begin
                parent_we    = 1'b1;
                parent_waddr = r_cur;
                parent_wdat  = r_cur;
                wall_we      = 1'b1;
                wall_waddr   = r_cur;
                wall_wdat    = gufwc_pkg::WALLS_ALL;
            end
            gufwc_pkg::ACT_WALK: begin
                // follow the link just read
                if (!fl.root) begin
                    parent_raddr = r_pdata;
                end
            end
            gufwc_pkg::ACT_SEEK2: begin
                parent_raddr = r_there;
                wall_raddr   = r_there;
            end
            gufwc_pkg::ACT_LINK: begin
                // first root goes under the neighbour's root
                parent_we = !fl.same;
                wall_we   = !fl.same;
            end
            gufwc_pkg::ACT_WALL2: begin
                wall_we    = 1'b1;
                wall_waddr = r_there;
                wall_wdat  = r_wn;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (parent_we) begin
            r_parent_mem[parent_waddr] <= parent_wdat;
        end
        r_pdata <= r_parent_mem[parent_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (wall_we) begin
            r_wall_mem[wall_waddr] <= wall_wdat;
        end
        r_wdata <= r_wall_mem[wall_raddr];
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (uw.act)
                gufwc_pkg::ACT_CLEAR: r_cur <= r_cur + CELL_W'(1);
                gufwc_pkg::ACT_WAIT:  if (accept) r_cur <= in_here;
                gufwc_pkg::ACT_WALK:  if (!fl.root) r_cur <= r_pdata;
                gufwc_pkg::ACT_SEEK2: r_cur <= r_there;
                default: ;
            endcase
            r_out_valid <= out_load | (r_out_valid & ~o_rsp.ready);
        end
    end

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        unique case (uw.act)
            gufwc_pkg::ACT_WAIT: begin
                if (accept) begin
                    r_here     <= in_here;
                    r_there    <= in_there;
                    r_dir      <= gufwc_pkg::t_dir'(i_req.direction);
                    r_cell_out <= in_cell_out;
                    r_nbr_out  <= in_nbr_out;
                    r_status   <= gufwc_pkg::STS_OUTSIDE;
                    r_wh       <= '0;
                    r_wn       <= '0;
                end
            end
            gufwc_pkg::ACT_HERE_MASK: r_wh <= r_wdata;
            gufwc_pkg::ACT_SEEK2:     r_r1 <= r_cur;
            gufwc_pkg::ACT_NBR_MASK:  r_wn <= r_wdata;
            gufwc_pkg::ACT_LINK: begin
                if (fl.same) begin
                    r_status <= gufwc_pkg::STS_CONNECTED;
                end else begin
                    r_status <= gufwc_pkg::STS_REMOVED;
                    r_wh     <= wh_cleared;
                    r_wn     <= wn_cleared;
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_out_status <= r_status;
            r_out_wh     <= r_wh;
            r_out_wn     <= r_wn;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.walls_here     = r_out_wh;
    assign o_rsp.walls_neighbor = r_out_wn;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // the table sweep follows every reset, so no request is taken right after
    a_no_req_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req.ready)
        else $error("request accepted before table sweep");

    // a result only appears from the emit step
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(uw.act == gufwc_pkg::ACT_EMIT))
        else $error("result loaded outside emit step");

    // outside-grid results never report a neighbour mask
    a_outside_no_nbr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == gufwc_pkg::STS_OUTSIDE)
            |-> (o_rsp.walls_neighbor == '0))
        else $error("outside result carries neighbour walls");

endmodule

### rtl/gufwc_seq.sv
module gufwc_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gufwc_pkg::t_flags i_flags,
    output gufwc_pkg::t_uword o_uword
);

    gufwc_pkg::t_step r_step;
    gufwc_pkg::t_step n_step;
    logic             hit;

    assign o_uword = gufwc_pkg::uprog(r_step);

    always_comb begin
        unique case (o_uword.cond)
            gufwc_pkg::C_NONE:     hit = 1'b0;
            gufwc_pkg::C_ALWAYS:   hit = 1'b1;
            gufwc_pkg::C_CLR_DONE: hit = i_flags.clr_done;
            gufwc_pkg::C_ACCEPT:   hit = i_flags.accept;
            gufwc_pkg::C_CELL_OUT: hit = i_flags.cell_out;
            gufwc_pkg::C_NBR_OUT:  hit = i_flags.nbr_out;
            gufwc_pkg::C_ROOT:     hit = i_flags.root;
            gufwc_pkg::C_SAME:     hit = i_flags.same;
            default:               hit = 1'b0;
        endcase
        if (o_uword.cond_out_free) begin
            hit = hit | i_flags.out_free;
        end

        if (hit) begin
            n_step = o_uword.target;
        end else if (o_uword.stay) begin
            n_step = r_step;
        end else begin
            n_step = gufwc_pkg::t_step'(r_step + 4'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= gufwc_pkg::ST_CLEAR;
        end else begin
            r_step <= n_step;
        end
    end

endmodule
